// File: hdl/assert_macros.svh
// Assertion macros shared by the blitter modules.
// Each use names a label, a property body and a message; clocked on clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset only.
`define ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/pu6b_pkg.sv
// Shared constants, types and functions of the 6x upscale blitter.
// No dependencies; used by every module in hdl.
`timescale 1ns / 1ps

package pu6b_pkg;

  localparam int SRC_WIDTH  = 96;
  localparam int SRC_HEIGHT = 64;
  localparam int SCALE      = 6;

  localparam int LEVEL_W   = 17;
  localparam int FRAC_W    = 16;
  localparam int BYTE_W    = 8;
  localparam int COLOR_W   = 3 * BYTE_W;
  localparam int ADDR_W    = 22;
  localparam int REG_W     = 12;
  localparam int CFG_IDX_W = 8;

  localparam int COL_W = (SRC_WIDTH > 1) ? $clog2(SRC_WIDTH) : 1;
  localparam int ROW_W = (SRC_HEIGHT > 1) ? $clog2(SRC_HEIGHT) : 1;
  localparam int SCL_W = $clog2(SCALE);
  localparam int OFS_W = REG_W + 1;
  localparam int PROD_W = 2 * OFS_W;
  localparam int QUOT_W = LEVEL_W + BYTE_W - FRAC_W;

  localparam int IMG_W = SRC_WIDTH * SCALE;
  localparam int IMG_H = SRC_HEIGHT * SCALE;

  localparam int S_TDATA_W = ((3 * LEVEL_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((ADDR_W + COLOR_W + 7) / 8) * 8;

  localparam logic [COL_W-1:0] COL_LAST = COL_W'(SRC_WIDTH - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(SRC_HEIGHT - 1);
  localparam logic [SCL_W-1:0] SCL_LAST = SCL_W'(SCALE - 1);

  localparam logic [CFG_IDX_W-1:0] REG_FB_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FB_HEIGHT = CFG_IDX_W'(1);

  localparam logic [REG_W-1:0] FB_WIDTH_RST  = REG_W'(656);
  localparam logic [REG_W-1:0] FB_HEIGHT_RST = REG_W'(512);
  localparam logic [REG_W-1:0] IMG_W_R       = REG_W'(IMG_W);
  localparam logic [REG_W-1:0] IMG_H_R       = REG_W'(IMG_H);

  typedef struct packed {
    logic [REG_W-1:0] fb_width;
    logic [REG_W-1:0] top;
    logic [REG_W-1:0] left;
  } cfg_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [ADDR_W-1:0]  row_prod;
    logic [OFS_W-1:0]   col_ofs;
    logic               frame_last;
  } prep_t;

  // (level * 255) >> 16, saturated to a byte
  function automatic logic [BYTE_W-1:0] to_byte(input logic [LEVEL_W-1:0] lv);
    logic [LEVEL_W+BYTE_W-1:0] p;
    logic [QUOT_W-1:0]         q;
    p = {lv, {BYTE_W{1'b0}}} - {{BYTE_W{1'b0}}, lv};
    q = p[LEVEL_W+BYTE_W-1:FRAC_W];
    return (|q[QUOT_W-1:BYTE_W]) ? {BYTE_W{1'b1}} : q[BYTE_W-1:0];
  endfunction

  // centering margin, zero when the image does not fit
  function automatic logic [REG_W-1:0] margin(input logic [REG_W-1:0] size,
                                              input logic [REG_W-1:0] used);
    logic [REG_W-1:0] diff;
    diff = size - used;
    return (size > used) ? (diff >> 1) : '0;
  endfunction

endpackage

// File: hdl/pu6b_cfg.sv
// Configuration registers: framebuffer width and the derived centering margins.
// Depends on pu6b_pkg.
`timescale 1ns / 1ps

module pu6b_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic [pu6b_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pu6b_pkg::REG_W-1:0]      cfg_data,
  output pu6b_pkg::cfg_t                  cfg
);

  pu6b_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.fb_width <= pu6b_pkg::FB_WIDTH_RST;
      regs.left     <= pu6b_pkg::margin(pu6b_pkg::FB_WIDTH_RST, pu6b_pkg::IMG_W_R);
      regs.top      <= pu6b_pkg::margin(pu6b_pkg::FB_HEIGHT_RST, pu6b_pkg::IMG_H_R);
    end else if (cfg_valid) begin
      if (cfg_index == pu6b_pkg::REG_FB_WIDTH) begin
        regs.fb_width <= cfg_data;
        regs.left     <= pu6b_pkg::margin(cfg_data, pu6b_pkg::IMG_W_R);
      end else if (cfg_index == pu6b_pkg::REG_FB_HEIGHT) begin
        regs.top <= pu6b_pkg::margin(cfg_data, pu6b_pkg::IMG_H_R);
      end
    end
  end

  assign cfg = regs;

endmodule

// File: hdl/pu6b_prep.sv
// Input register, source position counters, color conversion and block base
// address multiply, ending in a one-entry result register. Depends on pu6b_pkg.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module pu6b_prep (
  input  logic                          clk,
  input  logic                          rst,
  input  pu6b_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pu6b_pkg::LEVEL_W-1:0]  red_level,
  input  logic [pu6b_pkg::LEVEL_W-1:0]  green_level,
  input  logic [pu6b_pkg::LEVEL_W-1:0]  blue_level,
  output logic                          out_valid,
  input  logic                          out_ready,
  output pu6b_pkg::prep_t               out_item
);

  localparam logic [pu6b_pkg::OFS_W-1:0] SCALE_O = pu6b_pkg::OFS_W'(pu6b_pkg::SCALE);

  logic [pu6b_pkg::COL_W-1:0]   src_col;
  logic [pu6b_pkg::ROW_W-1:0]   src_row;
  logic                         a_valid;
  logic [pu6b_pkg::LEVEL_W-1:0] a_red;
  logic [pu6b_pkg::LEVEL_W-1:0] a_green;
  logic [pu6b_pkg::LEVEL_W-1:0] a_blue;
  logic [pu6b_pkg::COL_W-1:0]   a_col;
  logic [pu6b_pkg::ROW_W-1:0]   a_row;
  logic                         b_valid;
  pu6b_pkg::prep_t              b_item;
  pu6b_pkg::prep_t              b_item_next;

  logic                         b_ready;
  logic                         accept;
  logic [pu6b_pkg::OFS_W-1:0]   row_sum;
  logic [pu6b_pkg::PROD_W-1:0]  prod;

  assign b_ready  = !b_valid || out_ready;
  assign in_ready = !a_valid || b_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    row_sum = pu6b_pkg::OFS_W'(cfg.top) + pu6b_pkg::OFS_W'(a_row) * SCALE_O;
    prod    = pu6b_pkg::PROD_W'(row_sum) * pu6b_pkg::PROD_W'(cfg.fb_width);
    b_item_next.color = {pu6b_pkg::to_byte(a_red), pu6b_pkg::to_byte(a_green),
                         pu6b_pkg::to_byte(a_blue)};
    b_item_next.row_prod   = prod[pu6b_pkg::ADDR_W-1:0];
    b_item_next.col_ofs    = pu6b_pkg::OFS_W'(cfg.left) + pu6b_pkg::OFS_W'(a_col) * SCALE_O;
    b_item_next.frame_last = (a_col == pu6b_pkg::COL_LAST) && (a_row == pu6b_pkg::ROW_LAST);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_col <= '0;
      src_row <= '0;
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (in_ready) a_valid <= in_valid;
      if (b_ready) b_valid <= a_valid;
      if (accept) begin
        if (src_col == pu6b_pkg::COL_LAST) begin
          src_col <= '0;
          src_row <= (src_row == pu6b_pkg::ROW_LAST) ? '0 : src_row + 1'b1;
        end else begin
          src_col <= src_col + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_red   <= red_level;
      a_green <= green_level;
      a_blue  <= blue_level;
      a_col   <= src_col;
      a_row   <= src_row;
    end
    if (b_ready && a_valid) b_item <= b_item_next;
  end

  assign out_valid = b_valid;
  assign out_item  = b_item;

  `ASSERT_RUN(a_col_range, src_col <= pu6b_pkg::COL_LAST && src_row <= pu6b_pkg::ROW_LAST, "source position out of range")
  `ASSERT_RUN(a_frame_wrap, accept && src_col == pu6b_pkg::COL_LAST && src_row == pu6b_pkg::ROW_LAST |=> src_col == '0 && src_row == '0, "counters did not wrap at frame end")

endmodule

// File: hdl/pu6b_emit.sv
// Word sequencer: walks the 6x6 block of one prepared pixel, one word per
// cycle while out_ready is high, from an output register; needs pu6b_pkg.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module pu6b_emit (
  input  logic                          clk,
  input  logic                          rst,
  input  pu6b_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  pu6b_pkg::prep_t               in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pu6b_pkg::ADDR_W-1:0]   word_address,
  output logic [pu6b_pkg::COLOR_W-1:0]  packed_color,
  output logic                          pixel_done,
  output logic                          frame_done
);

  logic                         busy;
  logic [pu6b_pkg::SCL_W-1:0]   px;
  logic [pu6b_pkg::SCL_W-1:0]   py;
  logic [pu6b_pkg::ADDR_W-1:0]  addr;
  logic [pu6b_pkg::ADDR_W-1:0]  row_start;
  logic [pu6b_pkg::ADDR_W-1:0]  row_start_next;
  logic [pu6b_pkg::ADDR_W-1:0]  start;
  logic [pu6b_pkg::COLOR_W-1:0] color;
  logic                         frame_last;

  logic last_word;
  logic take;
  logic load;

  assign last_word      = (px == pu6b_pkg::SCL_LAST) && (py == pu6b_pkg::SCL_LAST);
  assign take           = busy && out_ready;
  assign in_ready       = !busy || (out_ready && last_word);
  assign load           = in_valid && in_ready;
  assign start          = in_item.row_prod + pu6b_pkg::ADDR_W'(in_item.col_ofs);
  assign row_start_next = row_start + pu6b_pkg::ADDR_W'(cfg.fb_width);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      px   <= '0;
      py   <= '0;
    end else if (load) begin
      busy       <= 1'b1;
      px         <= '0;
      py         <= '0;
      addr       <= start;
      row_start  <= start;
      color      <= in_item.color;
      frame_last <= in_item.frame_last;
    end else if (take) begin
      if (last_word) begin
        busy <= 1'b0;
        px   <= '0;
        py   <= '0;
      end else if (px == pu6b_pkg::SCL_LAST) begin
        px        <= '0;
        py        <= py + 1'b1;
        row_start <= row_start_next;
        addr      <= row_start_next;
      end else begin
        px   <= px + 1'b1;
        addr <= addr + 1'b1;
      end
    end
  end

  assign out_valid    = busy;
  assign word_address = addr;
  assign packed_color = color;
  assign pixel_done   = last_word;
  assign frame_done   = last_word && frame_last;

  `ASSERT_RUN(a_idle_rest, !busy |-> px == '0 && py == '0, "block position not at rest while idle")
  `ASSERT_RUN(a_step_addr, take && !last_word && px != pu6b_pkg::SCL_LAST |=> busy && addr == pu6b_pkg::ADDR_W'($past(addr) + 1'b1), "address did not step within a row")
  `ASSERT_RUN(a_frame_pix, busy && frame_done |-> pixel_done, "frame end without pixel end")

endmodule

// File: hdl/pixel_upscale_6x_blitter.sv
// Top level of the 6x nearest-neighbor upscale blitter.
// Depends on pu6b_pkg, pu6b_cfg, pu6b_prep and pu6b_emit.
`timescale 1ns / 1ps

// Each accepted source pixel yields 36 framebuffer writes (a 6x6 block, row by
// row) at one word per cycle while m_tready stays high; the output word port
// is what sets that rate. A pixel passes the input, result and output
// registers before its first word shows; two more pixels can be held while a
// block is being written, so writes run without gaps between pixels. Source
// column and row are counted internally from reset and wrap at the end of
// each 96x64 frame. The user writes registers over the cfg channel (index 0:
// fb_width, index 1: fb_height) only while idle; the block does not check it.

module pixel_upscale_6x_blitter (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pu6b_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pu6b_pkg::REG_W-1:0]       cfg_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // red_level [16:0], green_level [33:17], blue_level [50:34], zero pad
  input  logic [pu6b_pkg::S_TDATA_W-1:0]   s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // word_address [21:0], packed_color [45:22], zero pad
  output logic [pu6b_pkg::M_TDATA_W-1:0]   m_tdata,
  output logic                             m_tlast,
  // frame_done [0]
  output logic                             m_tuser
);

  pu6b_pkg::cfg_t               cfg;
  pu6b_pkg::prep_t              item;
  logic                         item_valid;
  logic                         item_ready;
  logic [pu6b_pkg::ADDR_W-1:0]  word_address;
  logic [pu6b_pkg::COLOR_W-1:0] packed_color;

  assign cfg_ready = 1'b1;

  pu6b_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pu6b_prep u_prep (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .red_level   (s_tdata[pu6b_pkg::LEVEL_W-1:0]),
    .green_level (s_tdata[2*pu6b_pkg::LEVEL_W-1:pu6b_pkg::LEVEL_W]),
    .blue_level  (s_tdata[3*pu6b_pkg::LEVEL_W-1:2*pu6b_pkg::LEVEL_W]),
    .out_valid   (item_valid),
    .out_ready   (item_ready),
    .out_item    (item)
  );

  pu6b_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (item_valid),
    .in_ready     (item_ready),
    .in_item      (item),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .word_address (word_address),
    .packed_color (packed_color),
    .pixel_done   (m_tlast),
    .frame_done   (m_tuser)
  );

  assign m_tdata = pu6b_pkg::M_TDATA_W'({packed_color, word_address});

endmodule

// File: bench/testbench.sv
// Self-checking bench for pixel_upscale_6x_blitter: random and directed pixels, per-word checks.
// Depends on hdl/pu6b_pkg.sv and the blitter RTL; the expected writes come from a local
// predictor that tracks source column, row and the framebuffer geometry.
`timescale 1ns / 1ps

module testbench;

  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_PRINTS   = 20;
  localparam logic [pu6b_pkg::CFG_IDX_W-1:0] REG_SPARE = pu6b_pkg::CFG_IDX_W'(2);

  typedef struct {
    logic [pu6b_pkg::LEVEL_W-1:0] red;
    logic [pu6b_pkg::LEVEL_W-1:0] green;
    logic [pu6b_pkg::LEVEL_W-1:0] blue;
  } pixel_t;

  typedef struct {
    logic [pu6b_pkg::ADDR_W-1:0]  addr;
    logic [pu6b_pkg::COLOR_W-1:0] color;
    logic                         pixel_end;
    logic                         frame_end;
  } fb_write_t;

  logic                           clk;
  logic                           rst = 1'b1;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [pu6b_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [pu6b_pkg::REG_W-1:0]     cfg_data = '0;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [pu6b_pkg::S_TDATA_W-1:0] s_tdata = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [pu6b_pkg::M_TDATA_W-1:0] m_tdata;
  logic                           m_tlast;
  logic                           m_tuser;

  pixel_t    pixel_queue[$];
  fb_write_t expected_writes[$];
  pixel_t    offered;
  fb_write_t got_write;

  int fb_w = 656;
  int fb_h = 512;
  int pix_col = 0;
  int pix_row = 0;

  int send_idle = 0;
  int recv_idle = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int mismatch_count = 0;
  int pixels_queued = 0;
  int pixels_accepted = 0;
  int writes_seen = 0;
  int frame_ends = 0;
  int reg_writes = 0;

  pixel_upscale_6x_blitter dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [pu6b_pkg::BYTE_W-1:0] level_byte(
      input logic [pu6b_pkg::LEVEL_W-1:0] lv);
    int unsigned v;
    v = (32'(lv) * 255) >> pu6b_pkg::FRAC_W;
    return (v > 255) ? 8'hFF : v[pu6b_pkg::BYTE_W-1:0];
  endfunction

  function automatic longint centering(input int size, input int used);
    return longint'((size > used) ? (size - used) / 2 : 0);
  endfunction

  task automatic predict_writes(input pixel_t px);
    longint    top;
    longint    left;
    fb_write_t w;
    bit        last_col;
    bit        last_row;
    top = centering(fb_h, pu6b_pkg::IMG_H);
    left = centering(fb_w, pu6b_pkg::IMG_W);
    last_col = (pix_col == pu6b_pkg::SRC_WIDTH - 1);
    last_row = (pix_row == pu6b_pkg::SRC_HEIGHT - 1);
    w.color = {level_byte(px.red), level_byte(px.green), level_byte(px.blue)};
    for (int dy = 0; dy < pu6b_pkg::SCALE; dy++) begin
      for (int dx = 0; dx < pu6b_pkg::SCALE; dx++) begin
        w.addr = pu6b_pkg::ADDR_W'((top + pix_row * pu6b_pkg::SCALE + dy) * fb_w
                                   + left + pix_col * pu6b_pkg::SCALE + dx);
        w.pixel_end = (dy == pu6b_pkg::SCALE - 1) && (dx == pu6b_pkg::SCALE - 1);
        w.frame_end = w.pixel_end && last_col && last_row;
        expected_writes.push_back(w);
      end
    end
    if (last_col) begin
      pix_col = 0;
      pix_row = last_row ? 0 : pix_row + 1;
    end else begin
      pix_col++;
    end
  endtask

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("mismatch on word %0d: %s", writes_seen, what);
  endtask

  // driver: one pixel word on the slave side, predicted when it is taken
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_writes(offered);
        pixels_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
          offered = pixel_queue.pop_front();
          s_tdata <= pu6b_pkg::S_TDATA_W'({offered.blue, offered.green, offered.red});
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver backpressure, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      writes_seen++;
      if (m_tuser)
        frame_ends++;
      if (expected_writes.size() == 0) begin
        report_mismatch("word with nothing expected");
      end else begin
        got_write = expected_writes.pop_front();
        if (m_tdata[pu6b_pkg::ADDR_W-1:0] !== got_write.addr)
          report_mismatch($sformatf("word_address %h, expected %h",
                                    m_tdata[pu6b_pkg::ADDR_W-1:0], got_write.addr));
        if (m_tdata[pu6b_pkg::ADDR_W +: pu6b_pkg::COLOR_W] !== got_write.color)
          report_mismatch($sformatf("packed_color %h, expected %h",
                                    m_tdata[pu6b_pkg::ADDR_W +: pu6b_pkg::COLOR_W],
                                    got_write.color));
        if (m_tlast !== got_write.pixel_end)
          report_mismatch($sformatf("pixel_done %b, expected %b", m_tlast,
                                    got_write.pixel_end));
        if (m_tuser !== got_write.frame_end)
          report_mismatch($sformatf("frame_done %b, expected %b", m_tuser,
                                    got_write.frame_end));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [pu6b_pkg::LEVEL_W-1:0] rand_level();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0)
      return '0;
    else if (pick == 1)
      return pu6b_pkg::LEVEL_W'(65536);
    else if (pick == 2)
      return pu6b_pkg::LEVEL_W'($urandom);
    else
      return pu6b_pkg::LEVEL_W'($urandom_range(65536));
  endfunction

  task automatic queue_pixel(input int r, input int g, input int b);
    pixel_t p;
    p.red = pu6b_pkg::LEVEL_W'(r);
    p.green = pu6b_pkg::LEVEL_W'(g);
    p.blue = pu6b_pkg::LEVEL_W'(b);
    pixel_queue.push_back(p);
    pixels_queued++;
  endtask

  task automatic queue_random(input int n);
    repeat (n) queue_pixel(int'(rand_level()), int'(rand_level()), int'(rand_level()));
  endtask

  task automatic wait_drain();
    while (pixel_queue.size() != 0 || s_tvalid || expected_writes.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [pu6b_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pu6b_pkg::REG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    reg_writes++;
    if (idx == pu6b_pkg::REG_FB_WIDTH)
      fb_w = int'(val);
    else if (idx == pu6b_pkg::REG_FB_HEIGHT)
      fb_h = int'(val);
  endtask

  task automatic set_geometry(input int w, input int h);
    write_reg(pu6b_pkg::REG_FB_WIDTH, pu6b_pkg::REG_W'(w));
    write_reg(pu6b_pkg::REG_FB_HEIGHT, pu6b_pkg::REG_W'(h));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle = 11;
    recv_idle = 66;
    // channel extremes, saturation and bit patterns at reset geometry
    queue_pixel(0, 0, 0);
    queue_pixel(65536, 65536, 65536);
    queue_pixel(65535, 65535, 65535);
    queue_pixel(131071, 131071, 131071);
    queue_pixel(65536, 0, 0);
    queue_pixel(0, 65536, 0);
    queue_pixel(0, 0, 65536);
    queue_pixel(1, 256, 257);
    queue_pixel(131071, 0, 65536);
    queue_pixel(98304, 32768, 16384);
    queue_pixel('h15555, 'h0AAAA, 'h1FFFF);
    queue_pixel('h0AAAA, 'h15555, 0);
    queue_pixel(255, 65281, 65280);
    queue_random(7);
    wait_drain();

    set_geometry(576, 384);
    queue_random(100);
    wait_drain();

    // tall, wide buffer: addresses wrap past 22 bits
    set_geometry(4095, 4095);
    queue_random(80);
    wait_drain();

    send_idle = 66;
    recv_idle = 11;
    // buffer smaller than the image: margins clamp to zero
    set_geometry(0, 0);
    write_reg(REG_SPARE, pu6b_pkg::REG_W'($urandom));
    queue_random(80);
    wait_drain();

    set_geometry($urandom_range(576, 2048), $urandom_range(384, 2048));
    queue_random(80);
    wait_drain();

    send_idle = 0;
    recv_idle = 0;
    set_geometry(2048, 2048);
    hold_left = 600;
    queue_random(40);
    wait_drain();

    // back to the reset geometry
    set_geometry(656, 512);
    queue_random(70);
    wait_drain();

    $display("%0d pixels in, %0d framebuffer words checked, %0d frame ends seen",
             pixels_accepted, writes_seen, frame_ends);
    $display("%0d register writes over seven geometries, %0d mismatches",
             reg_writes, mismatch_count);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
